>>> sv/sbm_pkg.sv
package sbm_pkg;

  localparam int unsigned StackDepthDefault = 64;
  localparam int unsigned WordWidth = 32;

  // opcodes
  localparam logic [31:0] OpPush = 32'd0;
  localparam logic [31:0] OpAdd  = 32'd1;
  localparam logic [31:0] OpSub  = 32'd2;
  localparam logic [31:0] OpMul  = 32'd3;
  localparam logic [31:0] OpDiv  = 32'd4;
  localparam logic [31:0] OpNeg  = 32'd5;
  localparam logic [31:0] OpDup  = 32'd6;
  localparam logic [31:0] OpHalt = 32'd7;

  // result status codes
  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StOverflow  = 3'd1;
  localparam logic [2:0] StUnderflow = 3'd2;
  localparam logic [2:0] StDivZero   = 3'd3;
  localparam logic [2:0] StPastEnd   = 3'd4;
  localparam logic [2:0] StBadOp     = 3'd5;
  localparam logic [2:0] StEmpty     = 3'd6;

  // datapath operations
  typedef enum logic [2:0] {
    AluAdd,
    AluSub,
    AluMul,
    AluDiv,
    AluNeg
  } alu_op_e;

  typedef struct packed {
    logic signed [31:0] word;
    logic               last_word;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] value;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic       rd_top;    // read top and second entries
    logic       wr_push;   // write operand word at depth
    logic       wr_dup;    // write top copy at depth
    logic       alu_start; // start operation on read operands
    alu_op_e    alu_op;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic alu_done;
    logic b_zero;
  } dp_sts_t;

endpackage

>>> sv/sbm_datapath.sv
module sbm_datapath #(
  parameter int unsigned StackDepth = sbm_pkg::StackDepthDefault,
  localparam int unsigned AW = $clog2(StackDepth)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sbm_pkg::dp_cmd_t   cmd_i,
  input  logic [AW:0]        depth_i,
  input  logic [31:0]        word_i,
  output sbm_pkg::dp_sts_t   sts_o,
  output logic [31:0]        top_o
);

  logic [31:0] mem_q [StackDepth];
  logic [31:0] top_q, sec_q;
  logic [AW-1:0] top_a, sec_a, wr_a;

  // operation unit state
  logic [31:0] res_q, res_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d, dvs_q, dvs_d;
  logic [32:0] rem_q, rem_d, trial;
  logic        negq_q, negq_d;
  logic [31:0] ua, ub;

  assign top_a = AW'(depth_i - 1'b1);
  assign sec_a = AW'(depth_i - 2'd2);
  assign wr_a  = depth_i[AW-1:0];

  // stack memory, registered reads of top two entries
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_top) begin
      top_q <= mem_q[top_a];
      sec_q <= mem_q[sec_a];
    end
    if (cmd_i.wr_push) begin
      mem_q[wr_a] <= word_i;
    end else if (cmd_i.wr_dup) begin
      mem_q[wr_a] <= top_q;
    end else if (done_q) begin
      mem_q[wr_a] <= res_q;
    end
  end

  assign top_o = top_q;
  assign sts_o = '{alu_done: done_q, b_zero: (top_q == '0)};

  // operation unit: simple ops computed and registered directly, one bit a cycle for divide
  assign ua = sec_q[31] ? 32'(-sec_q) : sec_q;
  assign ub = top_q[31] ? 32'(-top_q) : top_q;
  assign trial = {rem_q[31:0], quo_q[31]} - {1'b0, dvs_q};

  always_comb begin
    res_d  = res_q;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    negq_d = negq_q;
    if (cmd_i.alu_start) begin
      case (cmd_i.alu_op)
        sbm_pkg::AluAdd: begin res_d = sec_q + top_q; done_d = 1'b1; end
        sbm_pkg::AluSub: begin res_d = sec_q - top_q; done_d = 1'b1; end
        sbm_pkg::AluMul: begin res_d = 32'(sec_q * top_q); done_d = 1'b1; end
        sbm_pkg::AluNeg: begin res_d = 32'(-top_q); done_d = 1'b1; end
        sbm_pkg::AluDiv: begin
          busy_d = 1'b1;
          cnt_d  = 6'd32;
          quo_d  = ua;
          dvs_d  = ub;
          rem_d  = '0;
          negq_d = sec_q[31] ^ top_q[31];
        end
        default: begin res_d = '0; done_d = 1'b1; end
      endcase
    end else if (busy_q) begin
      // restoring division, one quotient bit a cycle
      if (!trial[32]) begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = negq_q ? 32'(-quo_d) : quo_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
    negq_q <= negq_d;
  end

endmodule

>>> sv/sbm_ctrl.sv
module sbm_ctrl #(
  parameter int unsigned StackDepth = sbm_pkg::StackDepthDefault,
  localparam int unsigned AW = $clog2(StackDepth)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sbm_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sbm_pkg::out_word_t out_data_o,
  output sbm_pkg::dp_cmd_t   cmd_o,
  output logic [AW:0]        depth_o,
  input  sbm_pkg::dp_sts_t   sts_i,
  input  logic [31:0]        top_i
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRead = 3'd1;
  localparam logic [2:0] SExec = 3'd2;
  localparam logic [2:0] SWait = 3'd3;

  logic [2:0]  state_q, state_d;
  logic [AW:0] depth_q, depth_d;
  logic        pend_q, pend_d, skip_q, skip_d, last_q, last_d;
  logic [31:0] op_q, op_d;
  logic        ov_q, ov_d;
  sbm_pkg::out_word_t od_q, od_d;
  logic        accept, emit;
  logic [2:0]  est;
  logic [31:0] eval;
  logic [AW:0] full;

  assign full = (AW+1)'(StackDepth);
  assign in_stall_o = (state_q != SIdle) || (ov_q && out_stall_i);
  assign accept = in_valid_i && !in_stall_o;
  assign out_valid_o = ov_q;
  assign out_data_o = od_q;
  assign depth_o = depth_q;

  always_comb begin
    state_d = state_q;
    depth_d = depth_q;
    pend_d  = pend_q;
    skip_d  = skip_q;
    last_d  = last_q;
    op_d    = op_q;
    ov_d    = ov_q && out_stall_i;
    od_d    = od_q;
    cmd_o   = '0;
    cmd_o.alu_op = sbm_pkg::AluAdd;
    emit = 1'b0;
    est  = sbm_pkg::StOk;
    eval = '0;
    case (state_q)
      SIdle: begin
        if (accept) begin
          last_d = in_data_i.last_word;
          op_d   = in_data_i.word;
          if (skip_q) begin
            if (in_data_i.last_word) skip_d = 1'b0;
          end else if (pend_q) begin
            pend_d = 1'b0;
            if (depth_q >= full) begin
              emit = 1'b1; est = sbm_pkg::StOverflow;
            end else begin
              cmd_o.wr_push = 1'b1;
              depth_d = depth_q + 1'b1;
              if (in_data_i.last_word) begin emit = 1'b1; est = sbm_pkg::StPastEnd; end
            end
          end else begin
            case (in_data_i.word)
              sbm_pkg::OpPush: begin
                pend_d = 1'b1;
                if (in_data_i.last_word) begin emit = 1'b1; est = sbm_pkg::StPastEnd; end
              end
              sbm_pkg::OpAdd, sbm_pkg::OpSub, sbm_pkg::OpMul, sbm_pkg::OpDiv: begin
                if (depth_q < 2) begin emit = 1'b1; est = sbm_pkg::StUnderflow; end
                else begin cmd_o.rd_top = 1'b1; state_d = SRead; end
              end
              sbm_pkg::OpNeg: begin
                if (depth_q == 0) begin emit = 1'b1; est = sbm_pkg::StUnderflow; end
                else begin cmd_o.rd_top = 1'b1; state_d = SRead; end
              end
              sbm_pkg::OpDup: begin
                if (depth_q == 0) begin emit = 1'b1; est = sbm_pkg::StUnderflow; end
                else if (depth_q >= full) begin emit = 1'b1; est = sbm_pkg::StOverflow; end
                else begin cmd_o.rd_top = 1'b1; state_d = SRead; end
              end
              sbm_pkg::OpHalt: begin
                if (depth_q == 0) begin emit = 1'b1; est = sbm_pkg::StEmpty; end
                else begin cmd_o.rd_top = 1'b1; state_d = SRead; end
              end
              default: begin emit = 1'b1; est = sbm_pkg::StBadOp; end
            endcase
          end
        end
      end
      SRead: begin
        // operands are registered, decide the action
        state_d = SIdle;
        case (op_q)
          sbm_pkg::OpHalt: begin emit = 1'b1; est = sbm_pkg::StOk; eval = top_i; end
          sbm_pkg::OpDup: begin
            cmd_o.wr_dup = 1'b1;
            depth_d = depth_q + 1'b1;
            if (last_q) begin emit = 1'b1; est = sbm_pkg::StPastEnd; end
          end
          sbm_pkg::OpNeg: begin
            cmd_o.alu_start = 1'b1; cmd_o.alu_op = sbm_pkg::AluNeg;
            depth_d = depth_q - 1'b1; state_d = SWait;
          end
          sbm_pkg::OpDiv: begin
            if (sts_i.b_zero) begin emit = 1'b1; est = sbm_pkg::StDivZero; end
            else begin
              cmd_o.alu_start = 1'b1; cmd_o.alu_op = sbm_pkg::AluDiv;
              depth_d = depth_q - 2'd2; state_d = SWait;
            end
          end
          sbm_pkg::OpSub: begin
            cmd_o.alu_start = 1'b1; cmd_o.alu_op = sbm_pkg::AluSub;
            depth_d = depth_q - 2'd2; state_d = SWait;
          end
          sbm_pkg::OpMul: begin
            cmd_o.alu_start = 1'b1; cmd_o.alu_op = sbm_pkg::AluMul;
            depth_d = depth_q - 2'd2; state_d = SWait;
          end
          default: begin
            cmd_o.alu_start = 1'b1; cmd_o.alu_op = sbm_pkg::AluAdd;
            depth_d = depth_q - 2'd2; state_d = SWait;
          end
        endcase
      end
      SWait: begin
        // result is written at depth by the datapath, then depth steps on
        if (sts_i.alu_done) begin
          depth_d = depth_q + 1'b1;
          state_d = SIdle;
          if (last_q) begin emit = 1'b1; est = sbm_pkg::StPastEnd; end
        end
      end
      default: state_d = SIdle;
    endcase
    if (emit) begin
      ov_d = 1'b1;
      od_d.status = est;
      od_d.value  = eval;
      depth_d = '0;
      pend_d  = 1'b0;
      skip_d  = (state_q == SIdle) ? !in_data_i.last_word : !last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      depth_q <= '0;
      pend_q  <= 1'b0;
      skip_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      pend_q  <= pend_d;
      skip_q  <= skip_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    op_q   <= op_d;
    od_q   <= od_d;
  end

endmodule

>>> sv/stack_bytecode_machine.sv
// Stack bytecode interpreter: takes one program word per accepted input, with
// last_word on the final one, and gives one result word per program (halt value
// or an error status). PUSH, its operand and words that fail at decode are
// handled at decode; DUP, HALT and a division by zero also wait for the
// registered read of the stack memory; ADD, SUB, MUL and NEG add the operation
// unit and the write back; DIV adds the divider, one quotient bit a cycle. A
// result word held by a stalled receiver also stalls the input. The stack is a
// memory of STACK_DEPTH entries, read at two addresses a cycle.
module stack_bytecode_machine #(
  parameter int unsigned STACK_DEPTH = sbm_pkg::StackDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sbm_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sbm_pkg::out_word_t out_data_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);

  sbm_pkg::dp_cmd_t cmd;
  sbm_pkg::dp_sts_t sts;
  logic [AW:0]      depth;
  logic [31:0]      top;

  sbm_ctrl #(.StackDepth(STACK_DEPTH)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cmd_o(cmd), .depth_o(depth), .sts_i(sts), .top_i(top)
  );

  sbm_datapath #(.StackDepth(STACK_DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .depth_i(depth), .word_i(in_data_i.word),
    .sts_o(sts), .top_o(top)
  );

endmodule
